### design/integer_to_text_formatter_defines.svh
// ============================================================================
// Integer-to-text formatter assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ============================================================================
`ifndef INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define ITF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define ITF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/itf_pkg.sv
// ============================================================================
// Integer-to-text formatter package
// Shared constants, register indexes, ASCII codes and digit array control types.
// ============================================================================
`default_nettype none

package itf_pkg;

    // Fixed field widths
    localparam int NUM_W      = 64;
    localparam int LEN_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int OUT_CAP    = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_FLAGS = 3'd4;

    // Flag bit positions
    localparam int FLG_UNSIGNED = 0;
    localparam int FLG_PLUS     = 1;
    localparam int FLG_SPACE    = 2;
    localparam int FLG_PREFIX   = 3;
    localparam int FLG_UPPER    = 4;
    localparam int FLG_ZERO     = 5;
    localparam int FLG_LEFT     = 6;

    // Radix limits and special bases
    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_MAX = 5'd16;
    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_HEX = 5'd16;

    // ASCII codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    // Digit array operations
    typedef enum logic [2:0] {
        ARR_HOLD,
        ARR_CLEAR,
        ARR_CONV,
        ARR_FLUSH,
        ARR_SHIFT
    } t_arr_op;

    typedef struct packed {
        t_arr_op op;
        logic    bit_in;
    } t_arr_ctrl;

    typedef struct packed {
        logic       carry_pending;
        logic       overflow;
        logic [3:0] top_digit;
    } t_arr_stat;

    // Map one digit value to its ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] v;
        v = {4'b0000, d};
        if (d < 4'd10) begin
            return CH_ZERO + v;
        end else if (upper) begin
            return CH_A_UP + v - 8'd10;
        end else begin
            return CH_A_LO + v - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

### design/integer_to_text_formatter.sv
// ============================================================================
// Integer-to-text formatter
// Turns one 64-bit integer into printf-style text, one character per beat.
// ============================================================================
// Usage:
//   Pulse start with i_number while busy is low; the number is taken at that
//   edge and busy rises until the last character has been shown. Characters
//   come out on o_text_char / o_char_index / o_last_char, each for exactly
//   one cycle with o_strobe high; o_last_char marks the final one. The
//   receiver cannot stall the stream. Registers are written through
//   i_cfg_valid / o_cfg_ready (always ready) with i_cfg_index and
//   i_cfg_data, by the user only while busy is low; the block does not check.
// Sequence per number:
//   The magnitude is fed bit-serially into the digit row. Pending carries
//   then drain, and leading zero digits are stripped (fewer than MAX_DIGITS
//   of them). The sizing states S_CALC and S_SIZE follow, then one character
//   per cycle is emitted, each shown the cycle after it is picked. Busy
//   falls while the last character is shown, so the next number can be
//   taken in that cycle. With an output limit of zero no beat is emitted.
// Reset:
//   Registers return to radix 10, width 0, digits 0, limit 64, flags 0;
//   any number in progress is dropped.
// ============================================================================
`default_nettype none

`include "integer_to_text_formatter_defines.svh"

module integer_to_text_formatter #(
    parameter int MAX_DIGITS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output      logic                            busy,
    input  wire logic signed [itf_pkg::NUM_W-1:0] i_number,
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [itf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [itf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output      logic                            o_strobe,
    output      logic [7:0]                      o_text_char,
    output      logic [5:0]                      o_char_index,
    output      logic                            o_last_char
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W = $clog2(itf_pkg::NUM_W);
    localparam int LW    = itf_pkg::LEN_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CONV  = 7'b0000010,
        S_FLUSH = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_CALC  = 7'b0010000,
        S_SIZE  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    // Configuration registers
    logic [4:0] r_radix;
    logic [6:0] r_field_width;
    logic [6:0] r_min_digits;
    logic [6:0] r_output_limit;
    logic [6:0] r_flags;

    // Control
    t_state                   r_state;
    logic [BIT_W-1:0]         r_bit_cnt;
    logic [CNT_W-1:0]         r_scan_cnt;
    logic [6:0]               r_k;
    logic [6:0]               r_n_emit;

    // Per-number payload
    logic [itf_pkg::NUM_W-1:0] r_mag;
    logic                      r_sign_len;
    logic [7:0]                r_sign_char;
    logic [1:0]                r_pl;
    logic [CNT_W-1:0]          r_place;
    logic [LW-1:0]             r_zero_cnt;
    logic [LW-1:0]             r_space_cnt;
    logic [LW-1:0]             r_b1;
    logic [LW-1:0]             r_b2;
    logic [LW-1:0]             r_b3;
    logic [LW-1:0]             r_b4;
    logic [LW-1:0]             r_b5;

    // Output beat
    logic       r_strobe;
    logic [7:0] r_char;
    logic [5:0] r_idx;
    logic       r_last;

    logic                 w_accept;
    logic [4:0]           w_base;
    logic                 w_neg;
    logic                 w_upper;
    logic                 w_left;
    itf_pkg::t_arr_ctrl   w_ctrl;
    itf_pkg::t_arr_stat   w_stat;

    logic [6:0]           w_place7;
    logic [6:0]           w_widest;
    logic signed [LW-1:0] w_zp;
    logic signed [LW-1:0] w_sp;
    logic signed [LW-1:0] w_zp_fix;
    logic signed [LW-1:0] w_sp_fix;

    logic [LW-1:0]        w_b1;
    logic [LW-1:0]        w_b2;
    logic [LW-1:0]        w_b3;
    logic [LW-1:0]        w_b4;
    logic [LW-1:0]        w_b5;
    logic [LW-1:0]        w_total;
    logic [6:0]           w_olim;
    logic [6:0]           w_n_emit;

    logic [LW-1:0]        w_k;
    logic [7:0]           w_char;
    logic                 w_in_digits;
    logic                 w_last;
    logic                 w_scan_go;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_upper     = r_flags[itf_pkg::FLG_UPPER];
    assign w_left      = r_flags[itf_pkg::FLG_LEFT];

    // Clamp the radix into its legal range
    always_comb begin
        if (r_radix < itf_pkg::BASE_MIN) begin
            w_base = itf_pkg::BASE_MIN;
        end else if (r_radix > itf_pkg::BASE_MAX) begin
            w_base = itf_pkg::BASE_MAX;
        end else begin
            w_base = r_radix;
        end
    end

    assign w_neg = !r_flags[itf_pkg::FLG_UNSIGNED] && i_number[itf_pkg::NUM_W-1];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix        <= 5'd10;
            r_field_width  <= 7'd0;
            r_min_digits   <= 7'd0;
            r_output_limit <= 7'd64;
            r_flags        <= 7'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                itf_pkg::REG_RADIX:        r_radix        <= i_cfg_data[4:0];
                itf_pkg::REG_FIELD_WIDTH:  r_field_width  <= i_cfg_data;
                itf_pkg::REG_MIN_DIGITS:   r_min_digits   <= i_cfg_data;
                itf_pkg::REG_OUTPUT_LIMIT: r_output_limit <= i_cfg_data;
                itf_pkg::REG_FORMAT_FLAGS: r_flags        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pad amounts from the digit count
    assign w_place7 = 7'(r_place);
    assign w_widest = (r_min_digits > w_place7) ? r_min_digits : w_place7;

    always_comb begin
        w_zp = $signed(LW'(r_min_digits)) - $signed(LW'(w_place7));
        w_sp = $signed(LW'(r_field_width)) - $signed(LW'(w_widest))
             - $signed(LW'(r_sign_len)) - $signed(LW'(r_pl));
        if (r_flags[itf_pkg::FLG_ZERO]) begin
            w_zp_fix = ((w_zp < 0) ? $signed(LW'(0)) : w_zp) + w_sp;
            w_sp_fix = '0;
        end else begin
            w_zp_fix = w_zp;
            w_sp_fix = w_sp;
        end
    end

    // Segment boundaries and emitted length
    assign w_b1    = w_left ? '0 : r_space_cnt;
    assign w_b2    = w_b1 + LW'(r_sign_len);
    assign w_b3    = w_b2 + LW'(r_pl);
    assign w_b4    = w_b3 + r_zero_cnt;
    assign w_b5    = w_b4 + LW'(r_place);
    assign w_total = w_b5 + (w_left ? r_space_cnt : '0);
    assign w_olim  = (r_output_limit > 7'(itf_pkg::OUT_CAP)) ? 7'(itf_pkg::OUT_CAP)
                                                            : r_output_limit;
    assign w_n_emit = (w_total < LW'(w_olim)) ? w_total[6:0] : w_olim;

    // Pick the character at the current position
    assign w_k = LW'(r_k);
    always_comb begin
        w_in_digits = 1'b0;
        if (w_k < r_b1) begin
            w_char = itf_pkg::CH_SPACE;
        end else if (w_k < r_b2) begin
            w_char = r_sign_char;
        end else if (w_k < r_b3) begin
            if (w_k == r_b2) begin
                w_char = itf_pkg::CH_ZERO;
            end else begin
                w_char = w_upper ? itf_pkg::CH_X_UP : itf_pkg::CH_X_LO;
            end
        end else if (w_k < r_b4) begin
            w_char = itf_pkg::CH_ZERO;
        end else if (w_k < r_b5) begin
            w_char      = itf_pkg::digit_char(w_stat.top_digit, w_upper);
            w_in_digits = 1'b1;
        end else begin
            w_char = itf_pkg::CH_SPACE;
        end
    end

    assign w_last    = (r_k == (r_n_emit - 7'd1));
    assign w_scan_go = !w_stat.overflow && (w_stat.top_digit == 4'd0)
                       && (r_scan_cnt != CNT_W'(MAX_DIGITS - 1));

    // Drive the digit row
    always_comb begin
        w_ctrl.op     = itf_pkg::ARR_HOLD;
        w_ctrl.bit_in = r_mag[itf_pkg::NUM_W-1];
        case (r_state)
            S_IDLE:  if (w_accept) w_ctrl.op = itf_pkg::ARR_CLEAR;
            S_CONV:  w_ctrl.op = itf_pkg::ARR_CONV;
            S_FLUSH: if (w_stat.carry_pending) w_ctrl.op = itf_pkg::ARR_FLUSH;
            S_SCAN:  if (w_scan_go) w_ctrl.op = itf_pkg::ARR_SHIFT;
            S_EMIT:  if (w_in_digits) w_ctrl.op = itf_pkg::ARR_SHIFT;
            default: w_ctrl.op = itf_pkg::ARR_HOLD;
        endcase
    end

    itf_digit_array #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_digits (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_base (w_base),
        .o_stat (w_stat)
    );

    // Sequence one number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (r_bit_cnt == BIT_W'(itf_pkg::NUM_W - 1)) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!w_stat.carry_pending) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!w_scan_go) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= S_SIZE;
                end
                S_SIZE: begin
                    r_state <= (w_n_emit == 7'd0) ? S_IDLE : S_EMIT;
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    if (w_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Counters and per-number payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_bit_cnt   <= '0;
                    r_mag       <= w_neg ? (itf_pkg::NUM_W'(0) - i_number) : i_number;
                    r_sign_len  <= 1'b0;
                    r_sign_char <= itf_pkg::CH_SPACE;
                    if (w_neg) begin
                        r_sign_len  <= 1'b1;
                        r_sign_char <= itf_pkg::CH_MINUS;
                    end else if (!r_flags[itf_pkg::FLG_UNSIGNED]) begin
                        if (r_flags[itf_pkg::FLG_PLUS]) begin
                            r_sign_len  <= 1'b1;
                            r_sign_char <= itf_pkg::CH_PLUS;
                        end else if (r_flags[itf_pkg::FLG_SPACE]) begin
                            r_sign_len  <= 1'b1;
                        end
                    end
                    r_pl <= 2'd0;
                    if (r_flags[itf_pkg::FLG_PREFIX]) begin
                        if (w_base == itf_pkg::BASE_HEX) begin
                            r_pl <= 2'd2;
                        end else if (w_base == itf_pkg::BASE_OCT) begin
                            r_pl <= 2'd1;
                        end
                    end
                end
            end
            S_CONV: begin
                // Feed the magnitude MSB first
                r_mag     <= {r_mag[itf_pkg::NUM_W-2:0], 1'b0};
                r_bit_cnt <= r_bit_cnt + BIT_W'(1);
                r_scan_cnt <= '0;
            end
            S_SCAN: begin
                if (w_scan_go) begin
                    r_scan_cnt <= r_scan_cnt + CNT_W'(1);
                end else begin
                    r_place <= CNT_W'(MAX_DIGITS) - r_scan_cnt;
                end
            end
            S_CALC: begin
                r_zero_cnt  <= (w_zp_fix < 0) ? '0 : LW'(w_zp_fix);
                r_space_cnt <= (w_sp_fix < 0) ? '0 : LW'(w_sp_fix);
            end
            S_SIZE: begin
                r_b1     <= w_b1;
                r_b2     <= w_b2;
                r_b3     <= w_b3;
                r_b4     <= w_b4;
                r_b5     <= w_b5;
                r_n_emit <= w_n_emit;
                r_k      <= '0;
            end
            S_EMIT: begin
                r_k    <= r_k + 7'd1;
                r_char <= w_char;
                r_idx  <= r_k[5:0];
                r_last <= w_last;
            end
            default: begin
            end
        endcase
    end

    assign o_strobe     = r_strobe;
    assign o_text_char  = r_char;
    assign o_char_index = r_idx;
    assign o_last_char  = r_last;

    // Assertions
    `ITF_ASSERT_NEXT(a_start_busy, start && !busy, busy,
        "accepted number did not raise busy")
    `ITF_ASSERT_SAME(a_last_idle, o_strobe && o_last_char, !busy,
        "still busy after the last character")
    `ITF_ASSERT_NEXT(a_beat_run, o_strobe && !o_last_char,
        o_strobe && (o_char_index == 6'($past(o_char_index) + 6'd1)),
        "character stream broke before the last character")
    `ITF_ASSERT_SAME(a_strobe_src, o_strobe, $past(r_state == S_EMIT),
        "character shown outside emission")

endmodule

`default_nettype wire

### design/itf_digit_array.sv
// ============================================================================
// Digit array
// Row of radix digit cells in carry-save form: doubles and adds one input bit
// per cycle, drains pending carries, shifts digits toward the top, and clears.
// ============================================================================
`default_nettype none

module itf_digit_array #(
    parameter int MAX_DIGITS = 64
) (
    input  wire logic              i_clk,
    input  wire itf_pkg::t_arr_ctrl i_ctrl,
    input  wire logic [4:0]        i_base,
    output itf_pkg::t_arr_stat     o_stat
);

    logic [3:0] r_dig [MAX_DIGITS];
    logic [1:0] r_car [MAX_DIGITS];
    logic       r_ovf;

    logic [1:0] w_quo [MAX_DIGITS];
    logic [3:0] w_rem [MAX_DIGITS];
    logic       w_dbl;
    logic       w_bin;
    logic       w_any_car;
    logic [5:0] w_base1;
    logic [5:0] w_base2;

    assign w_dbl   = (i_ctrl.op == itf_pkg::ARR_CONV);
    assign w_bin   = w_dbl && (i_base == itf_pkg::BASE_MIN);
    assign w_base1 = {1'b0, i_base};
    assign w_base2 = {i_base, 1'b0};

    // Per cell: digit plus pending carry, doubled plus input bit (cell 0 only) if converting
    for (genvar gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
        logic [4:0] w_acc;
        logic [5:0] w_sum;
        logic       w_in;
        logic [5:0] w_sub;

        assign w_in  = (gi == 0) ? i_ctrl.bit_in : 1'b0;
        assign w_acc = {1'b0, r_dig[gi]} + {3'b000, r_car[gi]};
        assign w_sum = w_dbl ? {w_acc, w_in} : {1'b0, w_acc};

        always_comb begin
            if (w_sum >= w_base2) begin
                w_quo[gi] = 2'd2;
                w_sub     = w_base2;
            end else if (w_sum >= w_base1) begin
                w_quo[gi] = 2'd1;
                w_sub     = w_base1;
            end else begin
                w_quo[gi] = 2'd0;
                w_sub     = 6'd0;
            end
        end

        assign w_rem[gi] = 4'(w_sum - w_sub);
    end

    // Flag any carry still in flight
    always_comb begin
        w_any_car = 1'b0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_any_car = w_any_car | (r_car[i] != 2'd0);
        end
    end

    // Update the row
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            itf_pkg::ARR_CLEAR: begin
                for (int i = 0; i < MAX_DIGITS; i++) begin
                    r_dig[i] <= '0;
                    r_car[i] <= '0;
                end
                r_ovf <= 1'b0;
            end
            itf_pkg::ARR_CONV, itf_pkg::ARR_FLUSH: begin
                if (w_bin) begin
                    // Base two: digits are the bits themselves
                    r_dig[0] <= {3'b000, i_ctrl.bit_in};
                    for (int i = 1; i < MAX_DIGITS; i++) begin
                        r_dig[i] <= r_dig[i-1];
                    end
                    r_ovf <= r_ovf | (r_dig[MAX_DIGITS-1] != 4'd0);
                end else begin
                    r_car[0] <= '0;
                    for (int i = 0; i < MAX_DIGITS; i++) begin
                        r_dig[i] <= w_rem[i];
                    end
                    for (int i = 1; i < MAX_DIGITS; i++) begin
                        r_car[i] <= w_quo[i-1];
                    end
                    r_ovf <= r_ovf | (w_quo[MAX_DIGITS-1] != 2'd0);
                end
            end
            itf_pkg::ARR_SHIFT: begin
                r_dig[0] <= '0;
                for (int i = 1; i < MAX_DIGITS; i++) begin
                    r_dig[i] <= r_dig[i-1];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.carry_pending = w_any_car;
    assign o_stat.overflow      = r_ovf;
    assign o_stat.top_digit     = r_dig[MAX_DIGITS-1];

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Integer-to-text formatter testbench
// Feeds 64-bit numbers through the start/busy port under a series of register
// settings, predicts the printf-style character stream of each number, and
// checks every character beat against that prediction in order.
// ============================================================================

module tb;

    localparam int DIGIT_LIMIT  = 64;
    localparam int DRAIN_CYCLES = 300;
    localparam int QUIET_LIMIT  = 5000;
    localparam int RAND_PHASES  = 20;
    localparam int RAND_ITEMS   = 23;
    localparam int IDLE_PLAN [4] = '{0, 70, 0, 26};

    typedef struct {
        logic [7:0] ch;
        logic [5:0] idx;
        logic       last;
    } t_text_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic signed [itf_pkg::NUM_W-1:0] i_number = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [itf_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [itf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_strobe;
    logic [7:0]            o_text_char;
    logic [5:0]            o_char_index;
    logic                  o_last_char;

    // Register shadow, reset values
    logic [4:0] cfg_radix = 5'd10;
    logic [6:0] cfg_field_width = 7'd0;
    logic [6:0] cfg_min_digits = 7'd0;
    logic [6:0] cfg_output_limit = 7'd64;
    logic [6:0] cfg_flags = 7'd0;

    logic [63:0] pending_numbers [$];
    t_text_beat  expected_beats [$];
    int          sender_idle_pct = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;

    integer_to_text_formatter #(
        .MAX_DIGITS(DIGIT_LIMIT)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_number(i_number),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe),
        .o_text_char(o_text_char),
        .o_char_index(o_char_index),
        .o_last_char(o_last_char)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Build the formatted field of one number and queue its emitted characters
    function automatic void predict_text(input logic [63:0] value);
        logic [63:0] mag;
        logic [63:0] base;
        logic [7:0]  sign_char;
        logic [7:0]  d;
        logic        upper;
        int          place;
        int          pre_chars;
        int          zero_fill;
        int          space_fill;
        int          widest;
        int          emit_count;
        logic [7:0]  digit_row [$];
        logic [7:0]  field [$];
        t_text_beat  beat;

        base = (cfg_radix < itf_pkg::BASE_MIN) ? 64'(itf_pkg::BASE_MIN) :
               (cfg_radix > itf_pkg::BASE_MAX) ? 64'(itf_pkg::BASE_MAX) : 64'(cfg_radix);
        mag = value;
        upper = cfg_flags[itf_pkg::FLG_UPPER];
        sign_char = 8'h00;
        pre_chars = 0;
        place = 0;

        // Sign only in signed mode; negative values take the negated magnitude
        if (!cfg_flags[itf_pkg::FLG_UNSIGNED]) begin
            if (mag[63]) begin
                sign_char = itf_pkg::CH_MINUS;
                mag = 64'd0 - mag;
            end else if (cfg_flags[itf_pkg::FLG_PLUS]) begin
                sign_char = itf_pkg::CH_PLUS;
            end else if (cfg_flags[itf_pkg::FLG_SPACE]) begin
                sign_char = itf_pkg::CH_SPACE;
            end
        end

        if (cfg_flags[itf_pkg::FLG_PREFIX]) begin
            if (base == 64'(itf_pkg::BASE_HEX)) pre_chars = 2;
            if (base == 64'(itf_pkg::BASE_OCT)) pre_chars = 1;
        end

        // Digits, least significant first
        do begin
            d = 8'(mag % base);
            if (d < 8'd10) begin
                digit_row.push_back(itf_pkg::CH_ZERO + d);
            end else begin
                digit_row.push_back((upper ? itf_pkg::CH_A_UP : itf_pkg::CH_A_LO)
                                    + d - 8'd10);
            end
            mag = mag / base;
            place++;
        end while (mag != 64'd0 && place < DIGIT_LIMIT);

        zero_fill = int'(cfg_min_digits) - place;
        widest = (int'(cfg_min_digits) > place) ? int'(cfg_min_digits) : place;
        space_fill = int'(cfg_field_width) - widest - ((sign_char != 8'h00) ? 1 : 0)
                     - pre_chars;

        // Zero pad folds the space pad into the zero fill, which may shrink it
        if (cfg_flags[itf_pkg::FLG_ZERO]) begin
            if (zero_fill < 0) zero_fill = 0;
            zero_fill += space_fill;
            space_fill = 0;
        end

        if (!cfg_flags[itf_pkg::FLG_LEFT]) begin
            for (int i = 0; i < space_fill; i++) field.push_back(itf_pkg::CH_SPACE);
        end
        if (sign_char != 8'h00) field.push_back(sign_char);
        if (pre_chars == 2) begin
            field.push_back(itf_pkg::CH_ZERO);
            field.push_back(upper ? itf_pkg::CH_X_UP : itf_pkg::CH_X_LO);
        end else if (pre_chars == 1) begin
            field.push_back(itf_pkg::CH_ZERO);
        end
        for (int i = 0; i < zero_fill; i++) field.push_back(itf_pkg::CH_ZERO);
        for (int i = place - 1; i >= 0; i--) field.push_back(digit_row[i]);
        if (cfg_flags[itf_pkg::FLG_LEFT]) begin
            for (int i = 0; i < space_fill; i++) field.push_back(itf_pkg::CH_SPACE);
        end

        // Drop characters past the output limit
        emit_count = (cfg_output_limit > 7'd64) ? 64 : int'(cfg_output_limit);
        if (field.size() < emit_count) emit_count = field.size();
        for (int k = 0; k < emit_count; k++) begin
            beat.ch = field[k];
            beat.idx = 6'(k);
            beat.last = (k == emit_count - 1);
            expected_beats.push_back(beat);
        end
    endfunction

    // Driver: offer the oldest pending number, hold it until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // hold the current beat
        end else begin
            if (start) begin
                predict_text(i_number);
                void'(pending_numbers.pop_front());
            end
            if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                start <= 1'b1;
                i_number <= pending_numbers[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each character beat with the oldest expectation
    always @(posedge i_clk) begin
        t_text_beat want;
        if (i_rst_n && o_strobe) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected character beat: text_char %h char_index %0d",
                       o_text_char, o_char_index);
                error_count++;
            end else begin
                want = expected_beats.pop_front();
                if (o_text_char !== want.ch) begin
                    $error("text_char expected %h actual %h", want.ch, o_text_char);
                    error_count++;
                end
                if (o_char_index !== want.idx) begin
                    $error("char_index expected %0d actual %0d", want.idx, o_char_index);
                    error_count++;
                end
                if (o_last_char !== want.last) begin
                    $error("last_char expected %b actual %b", want.last, o_last_char);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every number is taken and shown, then let the block drain
    task automatic settle_block();
        do @(posedge i_clk);
        while (pending_numbers.size() != 0 || start || busy || expected_beats.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [itf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [itf_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            itf_pkg::REG_RADIX:        cfg_radix = data[4:0];
            itf_pkg::REG_FIELD_WIDTH:  cfg_field_width = data;
            itf_pkg::REG_MIN_DIGITS:   cfg_min_digits = data;
            itf_pkg::REG_OUTPUT_LIMIT: cfg_output_limit = data;
            itf_pkg::REG_FORMAT_FLAGS: cfg_flags = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [6:0] radix, input logic [6:0] width,
                                input logic [6:0] digits, input logic [6:0] limit,
                                input logic [6:0] flags);
        settle_block();
        write_reg(itf_pkg::REG_RADIX, radix);
        write_reg(itf_pkg::REG_FIELD_WIDTH, width);
        write_reg(itf_pkg::REG_MIN_DIGITS, digits);
        write_reg(itf_pkg::REG_OUTPUT_LIMIT, limit);
        write_reg(itf_pkg::REG_FORMAT_FLAGS, flags);
    endtask

    function automatic logic [63:0] random_number();
        case ($urandom_range(0, 6))
            0, 1:    return {$urandom, $urandom};
            2:       return 64'($urandom_range(0, 999));
            3:       return 64'd0 - 64'($urandom_range(1, 999));
            4:       return {$urandom, $urandom} >> $urandom_range(0, 63);
            5:       return 64'd0 - ({$urandom, $urandom} >> $urandom_range(1, 63));
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 64'h8000_0000_0000_0000;
                    1:       return 64'h7FFF_FFFF_FFFF_FFFF;
                    2:       return '1;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [6:0] random_radix();
        logic [4:0] r;
        case ($urandom_range(0, 9))
            0, 1, 2: r = itf_pkg::BASE_HEX;
            3, 4:    r = itf_pkg::BASE_OCT;
            5, 6:    r = 5'd10;
            7:       r = 5'($urandom_range(2, 16));
            default: r = 5'($urandom_range(0, 31));
        endcase
        return {2'($urandom), r};
    endfunction

    function automatic logic [6:0] random_pad();
        return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 24));
    endfunction

    function automatic logic [6:0] random_limit();
        case ($urandom_range(0, 9))
            0:       return 7'($urandom_range(0, 127));
            1, 2:    return 7'($urandom_range(1, 16));
            default: return 7'd64;
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: decimal, signed, no padding
        pending_numbers = '{64'd0, 64'd1, '1, 64'h7FFF_FFFF_FFFF_FFFF,
                            64'h8000_0000_0000_0000, 64'd1234567890, 64'd0 - 64'd42};

        // Hex with plus sign and lower-case prefix, value zero included
        apply_config(7'd16, 7'd20, 7'd0, 7'd64,
                     7'((1 << itf_pkg::FLG_PREFIX) | (1 << itf_pkg::FLG_PLUS)));
        pending_numbers = '{64'd0, 64'd255, 64'd0 - 64'd255,
                            64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF};

        // Octal prefix, space sign, zero padding with precision
        sender_idle_pct = 70;
        apply_config(7'd8, 7'd12, 7'd5, 7'd64,
                     7'((1 << itf_pkg::FLG_PREFIX) | (1 << itf_pkg::FLG_SPACE)
                        | (1 << itf_pkg::FLG_ZERO)));
        pending_numbers = '{64'd0, 64'd8, 64'd0 - 64'd8};

        // Binary unsigned: all ones fills the whole digit row
        sender_idle_pct = 0;
        apply_config(7'd2, 7'd0, 7'd0, 7'd64,
                     7'((1 << itf_pkg::FLG_UNSIGNED) | (1 << itf_pkg::FLG_UPPER)));
        pending_numbers = '{'1, 64'h8000_0000_0000_0000};

        // Upper-case hex, left aligned, precision fill
        apply_config(7'd16, 7'd30, 7'd20, 7'd64,
                     7'((1 << itf_pkg::FLG_UPPER) | (1 << itf_pkg::FLG_PREFIX)
                        | (1 << itf_pkg::FLG_LEFT)));
        pending_numbers = '{64'h00AB_CDEF, '1};

        // Radix below range and an output limit of zero
        apply_config(7'd0, 7'd10, 7'd0, 7'd0, 7'd0);
        pending_numbers = '{64'd5};

        // Radix above range, limit above range, zero pad beyond the cap
        apply_config(7'd31, 7'd100, 7'd90, 7'd127, 7'(1 << itf_pkg::FLG_ZERO));
        pending_numbers = '{64'd77};

        // Negative space pad shrinks the zero fill
        apply_config(7'd10, 7'd3, 7'd8, 7'd64,
                     7'((1 << itf_pkg::FLG_ZERO) | (1 << itf_pkg::FLG_PLUS)));
        pending_numbers = '{64'd12345};

        // Truncation at a small output limit
        sender_idle_pct = 70;
        apply_config(7'd10, 7'd10, 7'd0, 7'd5, 7'd0);
        pending_numbers = '{64'd1234567};

        // Random phases, the first two at the register extremes
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                apply_config(7'd16, 7'd64, 7'd64, 7'd1, 7'd127);
            end else if (p == 1) begin
                apply_config(7'd2, 7'd0, 7'd0, 7'd64, 7'd0);
            end else begin
                apply_config(random_radix(), random_pad(), random_pad(),
                             random_limit(), 7'($urandom_range(0, 127)));
            end
            sender_idle_pct = IDLE_PLAN[p % 4];
            for (int i = 0; i < RAND_ITEMS; i++) begin
                pending_numbers.push_back(random_number());
            end
        end

        settle_block();
        if (expected_beats.size() != 0) begin
            $error("%0d expected character beats never arrived", expected_beats.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
